### sv/szcf_pkg.sv
// Shared types, constants and helpers for the zero crossing finder.
`timescale 1ns / 1ps
package szcf_pkg;

  localparam int unsigned CountCap  = 4096;
  localparam int unsigned SlotLimit = 256;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned DivSteps  = 64;
  localparam int unsigned StepW     = $clog2(DivSteps);

  localparam logic [1:0] RegWrapEnable   = 2'd0;
  localparam logic [1:0] RegPeriodLength = 2'd1;
  localparam logic [1:0] RegRootSlots    = 2'd2;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_RND,
    BK_OUT
  } bk_state_e;

  // one unit of work for the back end
  typedef struct packed {
    logic [31:0] xb;         // anchor position
    logic [31:0] mag_f;      // |fb|
    logic [32:0] mag_dx;     // |dx|
    logic [32:0] mag_df;     // |df|
    logic        add_q;      // root = xb + q instead of xb - q
    logic        root_valid;
    logic        from_wrap;
    logic        end_of_run;
    logic [7:0]  slot_index;
    logic [12:0] crossing_count;
  } job_t;

  function automatic logic [12:0] count_inc(input logic [12:0] c);
    count_inc = (c < 13'(CountCap)) ? c + 13'd1 : c;
  endfunction

  function automatic logic [7:0] slot_of(input logic [12:0] c, input logic [8:0] slots);
    logic [12:0] s;
    logic [12:0] u;
    s = (slots == 9'd0) ? 13'd1 : (slots > 9'(SlotLimit)) ? 13'(SlotLimit) : {4'd0, slots};
    u = (c < s) ? c : s;
    slot_of = 8'(u - 13'd1);
  endfunction

  function automatic job_t make_job(input logic [31:0] xb, input logic [31:0] fb,
                                    input logic [34:0] dx, input logic [32:0] df,
                                    input logic wrap, input logic eor,
                                    input logic [12:0] cnt, input logic [8:0] slots);
    job_t        j;
    logic [34:0] adx;
    logic        neg;
    adx              = dx[34] ? (35'd0 - dx) : dx;
    j.xb             = xb;
    j.mag_f          = fb[31] ? (32'd0 - fb) : fb;
    j.mag_dx         = adx[32:0];
    j.mag_df         = df[32] ? (33'd0 - df) : df;
    neg              = (fb[31] ^ dx[34]) && (j.mag_f != 32'd0) && (j.mag_dx != 33'd0);
    j.add_q          = neg ? !df[32] : df[32];
    j.root_valid     = 1'b1;
    j.from_wrap      = wrap;
    j.end_of_run     = eor;
    j.slot_index     = slot_of(cnt, slots);
    j.crossing_count = cnt;
    make_job         = j;
  endfunction

endpackage

### sv/sampled_zero_crossing_finder.sv
// Sampled zero crossing finder: top level with configuration registers.
// Roots pass the 4-deep job queue (it absorbs bursts), the product, 64-step
// bit-serial division, rounding and output register; a closing item without
// a root skips to the output. Samples without a crossing go in one per cycle
// while the queue has room and no wrap root waits; roots take the divider in turn.
// Reset (rst_ni, async low) clears set state, queue and output valid.
`timescale 1ns / 1ps
module sampled_zero_crossing_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // sample_position, sample_value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // root_position, slot_index, crossing_count
  output logic [1:0]  m_axis_tuser,  // root_valid, from_wrap
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic        wrap_en_q;
  logic [30:0] period_q;
  logic [8:0]  slots_q;

  logic           push, full, pop, empty;
  szcf_pkg::job_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_en_q <= 1'b0;
      period_q  <= '0;
      slots_q   <= 9'd16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        szcf_pkg::RegWrapEnable:   wrap_en_q <= cfg_data_i[0];
        szcf_pkg::RegPeriodLength: period_q  <= cfg_data_i[30:0];
        szcf_pkg::RegRootSlots:    slots_q   <= cfg_data_i[8:0];
        default: begin
        end
      endcase
    end
  end

  szcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pos_i       (s_axis_tdata[31:0]),
    .val_i       (s_axis_tdata[63:32]),
    .last_i      (s_axis_tlast),
    .wrap_en_i   (wrap_en_q),
    .period_i    (period_q),
    .slots_i     (slots_q),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  szcf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  szcf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .job_i     (pop_data),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

endmodule

### sv/szcf_fifo.sv
// Small job queue between the front and back ends.
`timescale 1ns / 1ps
module szcf_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  szcf_pkg::job_t   push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output szcf_pkg::job_t   pop_data_o,
  output logic             empty_o
);

  szcf_pkg::job_t                  mem_q [szcf_pkg::FifoDepth];
  logic [szcf_pkg::FifoAw-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [szcf_pkg::FifoAw:0]       cnt_q, cnt_d;

  assign full_o     = (cnt_q == (szcf_pkg::FifoAw+1)'(szcf_pkg::FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### sv/szcf_front.sv
// Front end: takes samples, detects sign changes and queues interpolation jobs.
`timescale 1ns / 1ps
module szcf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [31:0]      pos_i,
  input  logic [31:0]      val_i,
  input  logic             last_i,
  input  logic             wrap_en_i,
  input  logic [30:0]      period_i,
  input  logic [8:0]       slots_i,
  output logic             push_o,
  output szcf_pkg::job_t   push_data_o,
  input  logic             full_i
);

  logic [31:0] prev_pos_q, prev_val_q, first_pos_q, first_val_q;
  logic        have_prev_q;
  logic [12:0] count_q;
  logic        pend_q;
  szcf_pkg::job_t pend_job_q;

  logic        acc, pair, wrap;
  logic [31:0] fpos, fval;
  logic [12:0] c1, c2;
  logic [34:0] pdx, wdx;
  logic [32:0] pdf, wdf;
  szcf_pkg::job_t pair_job, wrap_job, close_job, job0;
  logic        has_job;

  assign in_ready_o = !pend_q && !full_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    fpos = have_prev_q ? first_pos_q : pos_i;
    fval = have_prev_q ? first_val_q : val_i;
    // a sign change is simply a difference in sign bits
    pair = have_prev_q && (prev_val_q[31] ^ val_i[31]);
    wrap = last_i && wrap_en_i && (val_i[31] ^ fval[31]);
    c1   = pair ? szcf_pkg::count_inc(count_q) : count_q;
    c2   = wrap ? szcf_pkg::count_inc(c1) : c1;
    pdx  = {{3{pos_i[31]}}, pos_i} - {{3{prev_pos_q[31]}}, prev_pos_q};
    pdf  = {val_i[31], val_i} - {prev_val_q[31], prev_val_q};
    wdx  = {{3{fpos[31]}}, fpos} - {{3{pos_i[31]}}, pos_i} + {4'd0, period_i};
    wdf  = {fval[31], fval} - {val_i[31], val_i};
    pair_job = szcf_pkg::make_job(pos_i, val_i, pdx, pdf, 1'b0, last_i && !wrap, c1, slots_i);
    wrap_job = szcf_pkg::make_job(fpos, fval, wdx, wdf, 1'b1, 1'b1, c2, slots_i);
    close_job                = '0;
    close_job.end_of_run     = 1'b1;
    close_job.crossing_count = c2;
    has_job = pair || wrap || last_i;
    job0    = pair ? pair_job : (wrap ? wrap_job : close_job);
  end

  assign push_o      = pend_q ? !full_i : (acc && has_job);
  assign push_data_o = pend_q ? pend_job_q : job0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pos_q  <= '0;
      prev_val_q  <= '0;
      first_pos_q <= '0;
      first_val_q <= '0;
      have_prev_q <= 1'b0;
      count_q     <= '0;
      pend_q      <= 1'b0;
    end else begin
      if (pend_q && !full_i) begin
        pend_q <= 1'b0;
      end
      if (acc) begin
        first_pos_q <= fpos;
        first_val_q <= fval;
        prev_pos_q  <= pos_i;
        prev_val_q  <= val_i;
        have_prev_q <= !last_i;
        count_q     <= last_i ? 13'd0 : c1;
        // both pairs cross on the last sample: the wrap root is held and pushed once the queue has room
        if (pair && wrap) begin
          pend_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pend_job_q <= wrap_job;
    end
  end

endmodule

### sv/szcf_back.sv
// Back end: product, bit-serial division, rounding and saturation of each root.
`timescale 1ns / 1ps
module szcf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  szcf_pkg::job_t   job_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [55:0]      m_data_o,
  output logic [1:0]       m_user_o,
  output logic             m_last_o
);

  szcf_pkg::bk_state_e state_q, state_d;
  szcf_pkg::job_t      job_q;
  logic [63:0]         prod_q;
  logic [33:0]         rem_q;
  logic [63:0]         quo_q;
  logic [40:0]         qr_q;
  logic [szcf_pkg::StepW-1:0] step_q;
  logic                m_valid_q;
  logic [55:0]         m_data_q;
  logic [1:0]          m_user_q;
  logic                m_last_q;

  logic [33:0] rem_sh;
  logic        qbit;
  logic [64:0] q_rnd;
  logic [41:0] root_w;
  logic [31:0] root_sat;
  logic        out_free, load;

  assign out_free = !m_valid_q || m_ready_i;
  assign pop_o    = (state_q == szcf_pkg::BK_IDLE) && !empty_i;
  assign load     = (state_q == szcf_pkg::BK_OUT) && out_free;

  always_comb begin
    rem_sh = {rem_q[32:0], prod_q[63]};
    qbit   = (rem_sh >= {1'b0, job_q.mag_df});
    q_rnd  = {1'b0, quo_q} + {64'd0, ({rem_q, 1'b0} >= {2'b00, job_q.mag_df})};
    root_w = job_q.add_q ? {{10{job_q.xb[31]}}, job_q.xb} + {1'b0, qr_q}
                         : {{10{job_q.xb[31]}}, job_q.xb} - {1'b0, qr_q};
    if (!root_w[41] && (root_w[40:31] != 10'd0)) begin
      root_sat = 32'h7fff_ffff;
    end else if (root_w[41] && (root_w[40:31] != 10'h3ff)) begin
      root_sat = 32'h8000_0000;
    end else begin
      root_sat = root_w[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      szcf_pkg::BK_IDLE: begin
        if (!empty_i) begin
          state_d = job_i.root_valid ? szcf_pkg::BK_MUL : szcf_pkg::BK_OUT;
        end
      end
      szcf_pkg::BK_MUL: state_d = szcf_pkg::BK_DIV;
      szcf_pkg::BK_DIV: begin
        if (step_q == szcf_pkg::StepW'(szcf_pkg::DivSteps - 1)) begin
          state_d = szcf_pkg::BK_RND;
        end
      end
      szcf_pkg::BK_RND: state_d = szcf_pkg::BK_OUT;
      szcf_pkg::BK_OUT: begin
        if (out_free) begin
          state_d = szcf_pkg::BK_IDLE;
        end
      end
      default: state_d = szcf_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= szcf_pkg::BK_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      szcf_pkg::BK_IDLE: begin
        job_q <= job_i;
        qr_q  <= '0;
      end
      szcf_pkg::BK_MUL: begin
        prod_q <= 64'(job_q.mag_f * job_q.mag_dx[31:0])
                + (job_q.mag_dx[32] ? {job_q.mag_f, 32'd0} : 64'd0);
        rem_q  <= '0;
        quo_q  <= '0;
        step_q <= '0;
      end
      szcf_pkg::BK_DIV: begin
        rem_q  <= qbit ? rem_sh - {1'b0, job_q.mag_df} : rem_sh;
        quo_q  <= {quo_q[62:0], qbit};
        prod_q <= {prod_q[62:0], 1'b0};
        step_q <= step_q + 1'b1;
      end
      szcf_pkg::BK_RND: begin
        // zero divisor leaves the anchor; quotient caps at 2^40
        if (job_q.mag_df == 33'd0) begin
          qr_q <= '0;
        end else if (q_rnd > 65'h100_0000_0000) begin
          qr_q <= 41'h100_0000_0000;
        end else begin
          qr_q <= q_rnd[40:0];
        end
      end
      default: begin
      end
    endcase
    if (load) begin
      m_data_q <= {3'd0, job_q.crossing_count, job_q.slot_index, root_sat};
      m_user_q <= {job_q.from_wrap, job_q.root_valid};
      m_last_q <= job_q.end_of_run;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;
  assign m_last_o  = m_last_q;

endmodule

### sv/szcf_checker.sv
// Port-level checks for the zero crossing finder, bound to the top level.
`timescale 1ns / 1ps
module szcf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_bare_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("bare item is not a closing item");

  a_bare_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[39:0] == 40'd0) && !m_axis_tuser[1])
    else $error("bare item carries root or slot");

  a_root_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[52:40] != 13'd0)
    else $error("root with zero count");

endmodule

bind sampled_zero_crossing_finder szcf_checker u_szcf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### sim/sampled_zero_crossing_finder_test.sv
// Self-checking testbench for the sampled zero crossing finder.
`timescale 1ns / 1ps
module sampled_zero_crossing_finder_test;

  typedef struct packed {
    logic [31:0] root;
    logic        has_root;
    logic [7:0]  slot;
    logic [12:0] count;
    logic        wrap;
    logic        eor;
  } root_item_t;

  typedef struct {
    int         pos;
    int         val;
    bit         last;
    bit         fixed;
    root_item_t want;
  } sample_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  sampled_zero_crossing_finder dut (.*);

  // predictor copy of registers and set state
  bit          wrap_on;
  longint      period;
  int          slots_cfg;
  longint      prev_pos, prev_val, first_pos, first_val;
  bit          have_prev;
  int          crossings;

  root_item_t  pending_roots[$];
  int          errors;
  int          cycles;
  bit          idle_on;
  bit          fixed_next;
  root_item_t  fixed_item;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit sign_change(longint fa, longint fb);
    return (fa < 0 && fb >= 0) || (fa >= 0 && fb < 0);
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] interp(longint xb, longint fb, longint dx, longint df);
    longint unsigned a, b, d, q;
    logic [127:0]    prod, quo, rem;
    longint          r;
    bit              add_q;
    a = magn(fb);
    b = magn(dx);
    d = magn(df);
    if (d == 0) return xb[31:0];
    prod = 128'(a) * 128'(b);
    quo  = prod / 128'(d);
    rem  = prod % 128'(d);
    q    = quo[63:0];
    if (rem >= 128'(d) - rem) q++;
    if (q > 64'd1 << 40) q = 64'd1 << 40;
    add_q = ((fb < 0) != (dx < 0) && a != 0 && b != 0) ? (df >= 0) : (df < 0);
    r = add_q ? xb + longint'(q) : xb - longint'(q);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic root_item_t found_root(logic [31:0] root, bit wrap);
    root_item_t it;
    int         s, used;
    if (crossings < szcf_pkg::CountCap) crossings++;
    s    = slots_cfg < 1 ? 1 :
           (slots_cfg > szcf_pkg::SlotLimit ? szcf_pkg::SlotLimit : slots_cfg);
    used = crossings < s ? crossings : s;
    it.root = root; it.has_root = 1'b1; it.slot = 8'(used - 1);
    it.count = 13'(crossings); it.wrap = wrap; it.eor = 1'b0;
    return it;
  endfunction

  task automatic predict_sample(longint x, longint f, bit last);
    root_item_t out[$];
    root_item_t it;
    if (have_prev && sign_change(prev_val, f))
      out.push_back(found_root(interp(x, f, x - prev_pos, f - prev_val), 1'b0));
    if (!have_prev) begin
      first_pos = x;
      first_val = f;
    end
    prev_pos = x;
    prev_val = f;
    if (!last) begin
      have_prev = 1'b1;
    end else begin
      if (wrap_on && sign_change(f, first_val))
        out.push_back(found_root(interp(first_pos, first_val, first_pos - x + period,
                                        first_val - f), 1'b1));
      if (out.size() == 0) begin
        it = '0;
        it.count = 13'(crossings);
        out.push_back(it);
      end
      out[out.size() - 1].eor = 1'b1;
      have_prev = 1'b0;
      crossings = 0;
    end
    if (fixed_next) out = '{fixed_item};
    foreach (out[i]) pending_roots.push_back(out[i]);
  endtask

  // input side: predict on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      predict_sample(longint'($signed(s_axis_tdata[31:0])),
                     longint'($signed(s_axis_tdata[63:32])), s_axis_tlast);
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // output side
  always @(posedge clk_i) begin
    root_item_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_roots.size() == 0) begin
        report("unexpected result", m_axis_tdata[31:0], 0);
      end else begin
        w = pending_roots.pop_front();
        if (m_axis_tdata[31:0] != w.root) report("root", m_axis_tdata[31:0], w.root);
        if (m_axis_tuser[0] != w.has_root) report("root_valid", m_axis_tuser[0], w.has_root);
        if (m_axis_tdata[39:32] != w.slot) report("slot", m_axis_tdata[39:32], w.slot);
        if (m_axis_tdata[52:40] != w.count) report("count", m_axis_tdata[52:40], w.count);
        if (m_axis_tuser[1] != w.wrap) report("from_wrap", m_axis_tuser[1], w.wrap);
        if (m_axis_tlast != w.eor) report("end_of_run", m_axis_tlast, w.eor);
      end
    end
  end

  // receiver stalls: mostly short, a few long
  int stall_left;
  always @(negedge clk_i) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < 60) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left <= ($urandom_range(19) == 0) ? $urandom_range(100, 20) : $urandom_range(2);
    end
  end

  task automatic send(int pos, int val, bit last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, pos};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    gap = 0;
    if (idle_on && $urandom_range(99) < 30)
      gap = ($urandom_range(15) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 1);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_roots.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      szcf_pkg::RegWrapEnable:   wrap_on = data[0];
      szcf_pkg::RegPeriodLength: period = longint'(data[30:0]);
      szcf_pkg::RegRootSlots:    slots_cfg = int'(data[8:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int rand_value();
    case ($urandom_range(5))
      0: return 0;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return int'($urandom_range(200)) - 100;
      3: return int'($urandom_range(2000000)) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_set();
    int n, pos, v;
    bit full;
    n    = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    full = $urandom_range(3) == 0;
    pos  = full ? $urandom : int'($urandom_range(100000)) - 50000;
    for (int i = 0; i < n; i++) begin
      v = rand_value();
      if (!full && $urandom_range(1)) v = (i % 2) ? -int'($urandom_range(70000)) :
                                                    int'($urandom_range(70000));
      send(pos, v, i == n - 1);
      pos = full ? $urandom : pos + int'($urandom_range(131072));
    end
  endtask

  function automatic root_item_t typed(logic [31:0] r, bit v, int s, int c, bit w);
    root_item_t it;
    it.root = r; it.has_root = v; it.slot = 8'(s); it.count = 13'(c);
    it.wrap = w; it.eor = 1'b1;
    return it;
  endfunction

  sample_row_t rows[$];
  int          left;

  initial begin
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0; cfg_valid_i = 1'b0; cfg_index_i = szcf_pkg::RegWrapEnable;
    cfg_data_i = '0; errors = 0; cycles = 0; stall_left = 0; idle_on = 1'b1;
    fixed_next = 1'b0;
    wrap_on = 1'b0; period = 0; slots_cfg = 16;
    prev_pos = 0; prev_val = 0; first_pos = 0; first_val = 0;
    have_prev = 1'b0; crossings = 0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    rows = '{
      '{0, 0, 1, 1, typed(0, 0, 0, 0, 0)},
      '{0, -65536, 0, 0, '0},
      '{65536, 65536, 1, 1, typed(32768, 1, 0, 1, 0)},
      '{32'h80000000, 32'h7fffffff, 0, 0, '0},
      '{32'h7fffffff, 32'h80000000, 0, 0, '0},
      '{32'h80000000, 32'h7fffffff, 0, 0, '0},
      '{32'h7fffffff, -1, 1, 0, '0},
      '{10, 0, 0, 0, '0},
      '{20, -5, 0, 0, '0},
      '{30, 0, 1, 0, '0},
      '{5, 7, 0, 0, '0},
      '{5, -7, 1, 0, '0},
      '{32'hffffffff, 32'hffffffff, 0, 0, '0},
      '{32'h55555555, 32'h2aaaaaaa, 1, 0, '0}
    };
    foreach (rows[i]) begin
      fixed_next = rows[i].fixed;
      fixed_item = rows[i].want;
      send(rows[i].pos, rows[i].val, rows[i].last);
    end
    wait_drained();
    fixed_next = 1'b0;

    // wrap pair, including a single-sample set and a zero wrap interval
    cfg_write(szcf_pkg::RegWrapEnable, 1);
    cfg_write(szcf_pkg::RegPeriodLength, 0);
    send(100, -3, 1);
    send(0, 5, 0); send(65536, -5, 1);
    send(65536, -5, 0); send(0, 5, 1);
    send(32'h7fffffff, 9, 0); send(32'h80000000, -9, 1);
    wait_drained();

    // long alternating set drives slot saturation
    cfg_write(szcf_pkg::RegRootSlots, 300);
    cfg_write(szcf_pkg::RegPeriodLength, 32'h7fffffff);
    idle_on = 1'b0;
    for (int i = 0; i < 600; i++) send(i * 16, (i % 2) ? -1000 : 1000, i == 599);
    idle_on = 1'b1;
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          cfg_write(szcf_pkg::RegRootSlots, 0);
          cfg_write(szcf_pkg::RegWrapEnable, 0);
        end
        1: begin
          cfg_write(szcf_pkg::RegRootSlots, 1);
          cfg_write(szcf_pkg::RegWrapEnable, 1);
          cfg_write(szcf_pkg::RegPeriodLength, 32'h00010000);
        end
        2: begin
          cfg_write(szcf_pkg::RegRootSlots, 256);
          cfg_write(szcf_pkg::RegPeriodLength, $urandom);
        end
        3: begin
          cfg_write(szcf_pkg::RegRootSlots, 511);
          cfg_write(szcf_pkg::RegPeriodLength, 32'hffffffff);
        end
        4: begin
          cfg_write(szcf_pkg::RegRootSlots, 3);
          cfg_write(szcf_pkg::RegPeriodLength, 0);
        end
        default: begin
          cfg_write(szcf_pkg::RegRootSlots, 16);
          cfg_write(szcf_pkg::RegWrapEnable, 1);
        end
      endcase
      idle_on = (ph != 4);
      left = 290;
      while (left > 0) begin
        random_set();
        left = left - 10;
      end
    end

    wait_drained();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
